### rtl/core/jec_pkg.sv
`default_nettype none
package jec_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int Z_W        = 32;
    localparam int C_W        = 31;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MAG_W      = Z_W;
    localparam int PROD_W     = 2 * MAG_W;
    localparam int SUM_W      = PROD_W + 1;

    // Bit weight of 4.0 in a product with 2*FRAC_BITS fraction bits
    localparam logic [SUM_W-1:0] FOUR_SQ = SUM_W'(1) << (2 * FRAC_BITS + 2);

    localparam logic signed [C_W-1:0] C_LIMIT     = C_W'(2) << FRAC_BITS;
    localparam logic signed [C_W-1:0] C_LIMIT_NEG = -(C_W'(2) << FRAC_BITS);

    localparam logic signed [C_W-1:0] C_REAL_RESET    = -C_W'(174615117);
    localparam logic signed [C_W-1:0] C_IMAG_RESET    = -C_W'(128375230);
    localparam logic [CNT_W-1:0]      MAX_COUNT_RESET = CNT_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_C_REAL    = 2'd0,
        CFG_C_IMAG    = 2'd1,
        CFG_MAX_COUNT = 2'd2,
        CFG_UNUSED    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_MUL   = 2'd1,
        ST_CHECK = 2'd2,
        ST_HOLD  = 2'd3
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic escaped;
        logic at_max;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

### rtl/core/jec_ctrl.sv
`default_nettype none
module jec_ctrl
    import jec_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   done;

    assign done = status.escaped || status.at_max;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!done) begin
                    state_next = ST_MUL;
                end else if (status.out_free) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        cmd.load   = 1'b0;
        cmd.step   = 1'b0;
        cmd.finish = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_MUL: begin
            end
            ST_CHECK: begin
                cmd.step   = !done;
                cmd.finish = done && status.out_free;
            end
            ST_HOLD: begin
                cmd.finish = status.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/jec_datapath.sv
`default_nettype none
module jec_datapath
    import jec_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire cmd_t                    cmd,
    input  wire logic signed [Z_W-1:0]   s_point_real,
    input  wire logic signed [Z_W-1:0]   s_point_imag,
    input  wire logic signed [C_W-1:0]   c_real,
    input  wire logic signed [C_W-1:0]   c_imag,
    input  wire logic        [CNT_W-1:0] max_count,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic             [CNT_W-1:0] m_escape_count,
    output status_t                      status
);

    logic signed [Z_W-1:0]   x_reg;
    logic signed [Z_W-1:0]   y_reg;
    logic        [CNT_W-1:0] count_reg;
    logic        [PROD_W-1:0] pxx_reg;
    logic        [PROD_W-1:0] pyy_reg;
    logic        [PROD_W-1:0] pxy_reg;
    logic                    m_valid_reg;
    logic        [CNT_W-1:0] m_count_reg;

    logic        [MAG_W-1:0] mag_x;
    logic        [MAG_W-1:0] mag_y;
    logic        [SUM_W-1:0] mag_sq;
    logic signed [Z_W+1:0]   xx;
    logic signed [Z_W+1:0]   yy;
    logic signed [Z_W+1:0]   xy2;
    logic signed [Z_W+1:0]   x_sum;
    logic signed [Z_W+1:0]   y_sum;
    logic signed [Z_W-1:0]   x_next;
    logic signed [Z_W-1:0]   y_next;

    assign mag_x = x_reg[Z_W-1] ? MAG_W'(-x_reg) : MAG_W'(x_reg);
    assign mag_y = y_reg[Z_W-1] ? MAG_W'(-y_reg) : MAG_W'(y_reg);

    // Products of magnitudes; x_reg and y_reg hold while these settle
    always_ff @(posedge aclk) begin
        pxx_reg <= mag_x * mag_x;
        pyy_reg <= mag_y * mag_y;
        pxy_reg <= mag_x * mag_y;
    end

    assign mag_sq = SUM_W'(pxx_reg) + SUM_W'(pyy_reg);

    // Truncate magnitudes, then restore the sign of the cross term
    assign xx  = $signed({2'b00, pxx_reg[FRAC_BITS +: Z_W]});
    assign yy  = $signed({2'b00, pyy_reg[FRAC_BITS +: Z_W]});
    assign xy2 = (x_reg[Z_W-1] ^ y_reg[Z_W-1])
               ? -$signed({2'b00, pxy_reg[FRAC_BITS-1 +: Z_W]})
               :  $signed({2'b00, pxy_reg[FRAC_BITS-1 +: Z_W]});

    assign x_sum  = xx - yy + (Z_W+2)'(c_real);
    assign y_sum  = xy2 + (Z_W+2)'(c_imag);
    assign x_next = x_sum[Z_W-1:0];
    assign y_next = y_sum[Z_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg     <= s_point_real;
            y_reg     <= s_point_imag;
            count_reg <= '0;
        end else if (cmd.step) begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_count_reg <= count_reg;
        end
    end

    assign status.escaped  = mag_sq > FOUR_SQ;
    assign status.at_max   = count_reg == max_count;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_escape_count = m_count_reg;

endmodule
`default_nettype wire

### rtl/core/julia_escape_count.sv
`default_nettype none
// Channel  Handshake          Payload
// s_       s_valid/s_ready    s_point_real[31:0], s_point_imag[31:0] (signed Q4.28)
// m_       m_valid/m_ready    m_escape_count[15:0]
// cfg_     cfg_valid/cfg_ready cfg_index[1:0], cfg_wdata[31:0]
//
// Each iteration of a point passes first through the three magnitude
// multipliers (ST_MUL) and then through the escape compare and update
// (ST_CHECK). The next point is taken once the core is idle,
// while the previous count may still wait in the output register.
// Reset restores c and max_count to their defaults; cfg_ready stays high.
module julia_escape_count
    import jec_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic signed [Z_W-1:0]    s_point_real,
    input  wire logic signed [Z_W-1:0]    s_point_imag,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic        [CNT_W-1:0]       m_escape_count,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic   [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic   [CFG_DATA_W-1:0]  cfg_wdata
);

    logic signed [C_W-1:0]   c_real_reg;
    logic signed [C_W-1:0]   c_imag_reg;
    logic        [CNT_W-1:0] max_count_reg;
    logic signed [C_W-1:0]   c_wdata;
    logic                    c_ok;
    cmd_t                    cmd;
    status_t                 status;

    assign cfg_ready = 1'b1;
    assign c_wdata   = $signed(cfg_wdata[C_W-1:0]);
    assign c_ok      = (c_wdata >= C_LIMIT_NEG) && (c_wdata <= C_LIMIT);

    // Drop c writes outside [-2, 2]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_real_reg    <= C_REAL_RESET;
            c_imag_reg    <= C_IMAG_RESET;
            max_count_reg <= MAX_COUNT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_C_REAL: begin
                    if (c_ok) begin
                        c_real_reg <= c_wdata;
                    end
                end
                CFG_C_IMAG: begin
                    if (c_ok) begin
                        c_imag_reg <= c_wdata;
                    end
                end
                CFG_MAX_COUNT: begin
                    max_count_reg <= cfg_wdata[CNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    jec_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    jec_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_point_real   (s_point_real),
        .s_point_imag   (s_point_imag),
        .c_real         (c_real_reg),
        .c_imag         (c_imag_reg),
        .max_count      (max_count_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .status         (status)
    );

endmodule
`default_nettype wire

### sim/julia_escape_count_tb.sv
module julia_escape_count_tb;
    import jec_pkg::*;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        logic signed [Z_W-1:0] re;
        logic signed [Z_W-1:0] im;
        bit                    wait_empty;
    } point_req_t;

    typedef struct {
        logic signed [Z_W-1:0] re;
        logic signed [Z_W-1:0] im;
        logic [CNT_W-1:0]      count;
    } count_due_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic signed [Z_W-1:0] s_point_real = '0;
    logic signed [Z_W-1:0] s_point_imag = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CNT_W-1:0]      m_escape_count;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the block's registers, updated as each write is accepted
    logic signed [63:0] c_re_now = 64'(C_REAL_RESET);
    logic signed [63:0] c_im_now = 64'(C_IMAG_RESET);
    logic [CNT_W-1:0]   cap_now  = MAX_COUNT_RESET;

    point_req_t points_pending[$];
    count_due_t counts_due[$];
    point_req_t next_req;
    count_due_t due;
    count_due_t got;

    int tx_idle_pct = 38;
    int rx_idle_pct = 52;
    int calm_left = 0;
    int cycle_count = 0;
    int mismatches = 0;

    julia_escape_count dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_point_real   (s_point_real),
        .s_point_imag   (s_point_imag),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_escape_count (m_escape_count),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    initial forever #2 aclk = ~aclk;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    // |z|^2 > 4, exact, with 2*FRAC_BITS fraction bits
    function automatic bit beyond_radius(input logic signed [63:0] x,
                                         input logic signed [63:0] y);
        logic [128:0] r;
        r = 129'(magnitude(x)) * 129'(magnitude(x)) + 129'(magnitude(y)) * 129'(magnitude(y));
        return r > (129'(1) << (2 * FRAC_BITS + 2));
    endfunction

    function automatic logic [CNT_W-1:0] escape_iterations(input logic signed [Z_W-1:0] re,
                                                          input logic signed [Z_W-1:0] im);
        logic signed [63:0] x, y, xx, yy, xy2;
        logic [127:0]       ax, ay;
        logic [CNT_W-1:0]   n;
        x = 64'(re);
        y = 64'(im);
        n = '0;
        if (!beyond_radius(x, y)) begin
            while (n < cap_now) begin
                ax = 128'(magnitude(x));
                ay = 128'(magnitude(y));
                // truncate magnitudes toward zero, then restore the sign
                xx = 64'((ax * ax) >> FRAC_BITS);
                yy = 64'((ay * ay) >> FRAC_BITS);
                xy2 = 64'(((ax * ay) << 1) >> FRAC_BITS);
                if (x[63] != y[63]) xy2 = -xy2;
                x = xx - yy + c_re_now;
                y = xy2 + c_im_now;
                n = n + 1'b1;
                if (beyond_radius(x, y)) break;
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] spread(input logic [31:0] span);
        return 32'($urandom_range(2 * span, 0)) - span;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("ERROR @%0d: %s", cycle_count, msg);
        mismatches++;
    endtask

    task automatic queue_point(input logic [Z_W-1:0] re, input logic [Z_W-1:0] im,
                               input bit wait_empty);
        point_req_t r;
        r.re = re;
        r.im = im;
        r.wait_empty = wait_empty;
        points_pending.push_back(r);
    endtask

    // Sample after the edge has settled, so a request popped at that edge is seen
    task automatic wait_drained();
        @(negedge aclk);
        while (points_pending.size() != 0 || s_valid || counts_due.size() != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    // Leaves cfg_valid high so back-to-back writes follow without a gap
    task automatic set_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        logic signed [63:0] v;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        v = 64'($signed(data[C_W-1:0]));
        case (idx)
            CFG_C_REAL:    if (v >= C_LIMIT_NEG && v <= C_LIMIT) c_re_now = v;
            CFG_C_IMAG:    if (v >= C_LIMIT_NEG && v <= C_LIMIT) c_im_now = v;
            CFG_MAX_COUNT: cap_now = data[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Request driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                due.re = s_point_real;
                due.im = s_point_imag;
                due.count = escape_iterations(s_point_real, s_point_imag);
                counts_due.push_back(due);
            end
            if (!s_valid || s_ready) begin
                if (points_pending.size() != 0
                    && (calm_left != 0 || $urandom_range(99) >= tx_idle_pct)
                    && !(points_pending[0].wait_empty && counts_due.size() != 0)) begin
                    next_req = points_pending.pop_front();
                    s_valid <= 1'b1;
                    s_point_real <= next_req.re;
                    s_point_imag <= next_req.im;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) m_ready <= (calm_left != 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    // Count monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (counts_due.size() == 0) begin
                note_mismatch($sformatf("count %0d with no request outstanding",
                                        m_escape_count));
            end else begin
                got = counts_due.pop_front();
                if (m_escape_count !== got.count)
                    note_mismatch($sformatf("point (%h, %h): count %0d, predicted %0d",
                                            got.re, got.im, m_escape_count, got.count));
            end
        end
    end

    always @(posedge aclk) begin
        if (calm_left != 0) calm_left <= calm_left - 1;
        else if ($urandom_range(149) == 0) calm_left <= $urandom_range(80, 20);
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("julia_escape_count: mismatch");
            $finish;
        end
    end

    initial begin
        int mode;
        int blk;
        int k;
        int sel;
        logic [31:0] v;
        logic [Z_W-1:0] re;
        logic [Z_W-1:0] im;

        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // Reset values: origin, field extremes, the radius-2 boundary
        queue_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        queue_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        queue_point(32'h2000_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h0000_0000, 32'hE000_0000, 1'b0);
        queue_point(32'h2000_0001, 32'h0000_0000, 1'b0);
        queue_point(32'h1000_0000, 32'h0800_0000, 1'b1);
        queue_point(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        wait_drained();

        // Zero cap; c just past +-2 must be dropped; unknown index does nothing
        set_reg(CFG_MAX_COUNT, 32'hFFFF_0000);
        set_reg(CFG_C_REAL, 32'h2000_0001);
        set_reg(CFG_C_IMAG, 32'h5FFF_FFFF);
        set_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        queue_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h1000_0000, 32'hF000_0000, 1'b0);
        wait_drained();

        // c at both limits, cap of one
        set_reg(CFG_MAX_COUNT, 32'h0000_0001);
        set_reg(CFG_C_REAL, 32'(C_LIMIT));
        set_reg(CFG_C_IMAG, 32'h8000_0000 | 32'(C_LIMIT_NEG));
        cfg_valid <= 1'b0;
        queue_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h0800_0000, 32'h0000_0000, 1'b0);
        wait_drained();

        // Full cap: the origin under c = 0 never escapes
        set_reg(CFG_C_REAL, 32'h0000_0000);
        set_reg(CFG_C_IMAG, 32'h0000_0000);
        set_reg(CFG_MAX_COUNT, 32'h0000_FFFF);
        cfg_valid <= 1'b0;
        queue_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h2000_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h1800_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h0000_0000, 32'h2000_0000, 1'b0);
        wait_drained();

        // c = -2 holds z on the real axis at 2; bit 31 of the data is ignored
        set_reg(CFG_C_REAL, 32'(C_LIMIT_NEG));
        set_reg(CFG_C_IMAG, 32'h8000_0000);
        set_reg(CFG_MAX_COUNT, 32'hA5A5_0010);
        cfg_valid <= 1'b0;
        queue_point(32'h0000_0000, 32'h0000_0000, 1'b0);
        queue_point(32'h1000_0000, 32'h0000_0000, 1'b0);

        for (mode = 0; mode < 3; mode++) begin
            wait_drained();
            tx_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 52 : 0;
            rx_idle_pct = (mode == 0) ? 52 : (mode == 1) ? 38 : 0;
            for (blk = 0; blk < 4; blk++) begin
                wait_drained();
                sel = $urandom_range(9);
                v = (sel < 6) ? spread(32'h0C00_0000) :
                    (sel < 9) ? spread(32'h2000_0000) : spread(32'h3FFF_FFFF);
                set_reg(CFG_C_REAL, {1'($urandom), v[30:0]});
                sel = $urandom_range(9);
                v = (sel < 6) ? spread(32'h0C00_0000) :
                    (sel < 9) ? spread(32'h2000_0000) : spread(32'h3FFF_FFFF);
                set_reg(CFG_C_IMAG, {1'($urandom), v[30:0]});
                sel = $urandom_range(99);
                v = (sel < 70) ? $urandom_range(64, 1) :
                    (sel < 90) ? $urandom_range(160, 65) : $urandom_range(255, 0);
                set_reg(CFG_MAX_COUNT, {16'($urandom), v[15:0]});
                if ($urandom_range(3) == 0) set_reg(CFG_UNUSED, $urandom);
                cfg_valid <= 1'b0;
                for (k = 0; k < 71; k++) begin
                    sel = $urandom_range(99);
                    if (sel < 15) begin
                        re = $urandom;
                        im = $urandom;
                    end else if (sel < 45) begin
                        re = spread(32'h0800_0000);
                        im = spread(32'h0800_0000);
                    end else begin
                        re = spread(32'h2000_0000);
                        im = spread(32'h2000_0000);
                    end
                    queue_point(re, im, $urandom_range(39) == 0);
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("julia_escape_count: match");
        else
            $display("julia_escape_count: mismatch");
        $finish;
    end

endmodule
